// ===== rtl/dmmt_pkg.sv =====
// shared constants, types and helpers of the module tally block
package dmmt_pkg;
  localparam int MAX_MAP     = 24;
  localparam int MAX_REGIONS = 6;
  localparam int WIN_SIDE    = MAX_MAP + 2;
  localparam int COLOR_DEPTH = WIN_SIDE * WIN_SIDE;
  localparam int TALLY_DEPTH = MAX_MAP * MAX_MAP;
  localparam int CADDR_W     = $clog2(COLOR_DEPTH);
  localparam int TADDR_W     = $clog2(TALLY_DEPTH);

  localparam logic [2:0] REG_OFF_COLOR = 3'd0;
  localparam logic [2:0] REG_ON_COLOR  = 3'd1;
  localparam logic [2:0] REG_MAP_W     = 3'd2;
  localparam logic [2:0] REG_MAP_H     = 3'd3;
  localparam logic [2:0] REG_REG_ACR   = 3'd4;
  localparam logic [2:0] REG_REG_DOWN  = 3'd5;

  localparam logic [1:0] PASS_UP    = 2'd0;
  localparam logic [1:0] PASS_LEFT  = 2'd1;
  localparam logic [1:0] PASS_DOWN  = 2'd2;
  localparam logic [1:0] PASS_RIGHT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_RD, ST_EVAL, ST_UPD, ST_ROW_RD, ST_ROW_ACC, ST_OUT
  } state_t;

  function automatic logic [4:0] clamp_map(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'(MAX_MAP)) return 5'(MAX_MAP);
    return v;
  endfunction

  function automatic logic [2:0] clamp_reg(input logic [2:0] v);
    if (v == 3'd0) return 3'd1;
    if (v > 3'(MAX_REGIONS)) return 3'(MAX_REGIONS);
    return v;
  endfunction
endpackage

// ===== rtl/dmmt_in_if.sv =====
// sample channel
interface dmmt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] region_x;
  logic [2:0] region_y;
  logic [4:0] window_row;
  logic [4:0] window_col;
  logic [7:0] color;
  logic       last;
  modport source (output valid, region_x, region_y, window_row, window_col, color, last,
                  input ready);
  modport sink (input valid, region_x, region_y, window_row, window_col, color, last,
                output ready);
endinterface

// ===== rtl/dmmt_out_if.sv =====
// row result channel
interface dmmt_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] row_bits;
  logic [4:0]  map_row;
  logic [7:0]  array_row;
  logic [14:0] array_index;
  logic        row_last;
  modport source (output valid, row_bits, map_row, array_row, array_index, row_last,
                  input ready);
  modport sink (input valid, row_bits, map_row, array_row, array_index, row_last,
                output ready);
endinterface

// ===== rtl/data_matrix_module_tally_top.sv =====
// Data Matrix region module tally: samples are taken one beat per cycle while
// idle and stored in a color memory; the beat marked last starts an evaluation
// that clears all 576 entries of the tally memory (no samples taken), then makes
// the four directional passes (read color, read tally, write back per module),
// and finally reads the tally memory module by module to emit one row beat per
// map row. No samples are taken until the evaluation ends and the output has
// accepted the last row beat, so output stalls lengthen the evaluation.
module data_matrix_module_tally_top
  import dmmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  dmmt_in_if.sink     in_ch,
  dmmt_out_if.source  out_ch
);
  logic [7:0] off_color, on_color;
  logic [4:0] map_width, map_height;
  logic [2:0] regions_across, regions_down;

  state_t state, state_next;

  logic [4:0] w, h;
  logic [2:0] rx, ry;
  logic [7:0] thr;
  logic       dark;
  logic [6:0] factor;
  logic [1:0] pass;
  logic [4:0] line, pos, weight;
  logic       first, on_st;
  logic signed [8:0] t_prev;
  logic [TADDR_W-1:0] clr_cnt;
  logic [4:0] r, c;
  logic [23:0] bits;
  logic [7:0] arow_base, raw, rxw, arow;

  logic [7:0] color_mem [COLOR_DEPTH];
  logic [7:0] tally_mem [TALLY_DEPTH];
  logic [7:0] color_q, tally_q;
  logic [CADDR_W-1:0] c_waddr, c_raddr;
  logic [TADDR_W-1:0] t_waddr, t_raddr;
  logic [7:0] t_wdata;
  logic       c_we, t_we;

  logic       in_acc, vert, fwd;
  logic [4:0] extent, nline, pos_adv, start_pos, crow, ccol, mr, mc;
  logic signed [8:0]  t_new;
  logic signed [10:0] lo_lim, hi_lim;
  logic       on_new, init_on;
  logic [7:0] dcol;
  logic [17:0] thr_prod;
  logic [4:0] w_c, h_c;
  logic [2:0] ra_c, rd_c, rx_c, ry_c;

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[4:2])
      REG_OFF_COLOR: prdata = {24'd0, off_color};
      REG_ON_COLOR:  prdata = {24'd0, on_color};
      REG_MAP_W:     prdata = {27'd0, map_width};
      REG_MAP_H:     prdata = {27'd0, map_height};
      REG_REG_ACR:   prdata = {29'd0, regions_across};
      REG_REG_DOWN:  prdata = {29'd0, regions_down};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      off_color <= 8'd255;
      on_color <= 8'd0;
      map_width <= 5'd8;
      map_height <= 5'd8;
      regions_across <= 3'd1;
      regions_down <= 3'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_OFF_COLOR: off_color <= pwdata[7:0];
        REG_ON_COLOR:  on_color <= pwdata[7:0];
        REG_MAP_W:     map_width <= pwdata[4:0];
        REG_MAP_H:     map_height <= pwdata[4:0];
        REG_REG_ACR:   regions_across <= pwdata[2:0];
        REG_REG_DOWN:  regions_down <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (c_we) color_mem[c_waddr] <= in_ch.color;
    color_q <= color_mem[c_raddr];
  end

  always_ff @(posedge clk) begin
    if (t_we) tally_mem[t_waddr] <= t_wdata;
    tally_q <= tally_mem[t_raddr];
  end

  // pass geometry
  assign vert      = (pass == PASS_UP) || (pass == PASS_DOWN);
  assign fwd       = (pass == PASS_UP) || (pass == PASS_RIGHT);
  assign extent    = vert ? h : w;
  assign nline     = vert ? w : h;
  assign start_pos = fwd ? 5'd0 : extent + 5'd1;
  assign pos_adv   = fwd ? pos + 5'd1 : pos - 5'd1;
  assign crow      = vert ? pos : line;
  assign ccol      = vert ? line : pos;
  assign mr        = crow - 5'd1;
  assign mc        = ccol - 5'd1;
  assign init_on   = fwd || ((vert ? (rx[0] & w[0]) : (ry[0] & h[0])) == line[0]);

  assign t_new  = dark ? $signed({1'b0, off_color}) - $signed({1'b0, color_q})
                       : $signed({1'b0, color_q}) - $signed({1'b0, off_color});
  assign lo_lim = 11'(t_prev) - $signed({3'b0, thr});
  assign hi_lim = 11'(t_prev) + $signed({3'b0, thr});
  assign on_new = on_st ? !(11'(t_new) < lo_lim) : (11'(t_new) > hi_lim);

  assign in_acc = in_ch.valid && in_ch.ready;
  assign c_we   = in_acc && (in_ch.window_row < 5'(WIN_SIDE)) &&
                  (in_ch.window_col < 5'(WIN_SIDE));
  assign c_waddr = CADDR_W'(in_ch.window_row) * CADDR_W'(WIN_SIDE) +
                   CADDR_W'(in_ch.window_col);
  assign c_raddr = CADDR_W'(crow) * CADDR_W'(WIN_SIDE) + CADDR_W'(ccol);

  always_comb begin
    t_we = 1'b0;
    t_waddr = TADDR_W'(mr) * TADDR_W'(MAX_MAP) + TADDR_W'(mc);
    t_wdata = tally_q + {2'b0, weight, 1'b0};
    t_raddr = TADDR_W'(mr) * TADDR_W'(MAX_MAP) + TADDR_W'(mc);
    case (state)
      ST_CLEAR: begin
        t_we = 1'b1;
        t_waddr = clr_cnt;
        t_wdata = 8'd0;
      end
      ST_UPD: t_we = on_st;
      ST_ROW_RD: t_raddr = TADDR_W'(r) * TADDR_W'(MAX_MAP) + TADDR_W'(c);
      default: ;
    endcase
  end

  // clamped configuration, taken at the last beat
  assign w_c  = clamp_map(map_width);
  assign h_c  = clamp_map(map_height);
  assign ra_c = clamp_reg(regions_across);
  assign rd_c = clamp_reg(regions_down);
  assign rx_c = (in_ch.region_x < ra_c) ? in_ch.region_x : ra_c - 3'd1;
  assign ry_c = (in_ch.region_y < rd_c) ? in_ch.region_y : rd_c - 3'd1;
  assign dcol = (off_color > on_color) ? off_color - on_color : on_color - off_color;
  // divide 2d+2 by five through a reciprocal
  assign thr_prod = 18'({1'b0, dcol, 1'b0} + 10'd2) * 18'd205;

  assign in_ch.ready = (state == ST_IDLE);

  // state machine
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_acc && in_ch.last) state_next = ST_CLEAR;
      ST_CLEAR: if (clr_cnt == TADDR_W'(TALLY_DEPTH - 1)) state_next = ST_RD;
      ST_RD:    state_next = ST_EVAL;
      ST_EVAL:  state_next = first ? ST_RD : ST_UPD;
      ST_UPD: begin
        if (weight != 5'd1) state_next = ST_RD;
        else if (line == nline && pass == PASS_RIGHT) state_next = ST_ROW_RD;
        else state_next = ST_RD;
      end
      ST_ROW_RD:  state_next = ST_ROW_ACC;
      ST_ROW_ACC: state_next = (c == w - 5'd1) ? ST_OUT : ST_ROW_RD;
      ST_OUT: begin
        if (out_ch.ready) state_next = (r == h - 5'd1) ? ST_IDLE : ST_ROW_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      clr_cnt <= '0;
      pass <= PASS_UP;
      first <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc && in_ch.last) begin
            w <= w_c;
            h <= h_c;
            rx <= rx_c;
            ry <= ry_c;
            dark <= off_color > on_color;
            thr <= thr_prod[17:10];
            factor <= {1'b0, w_c, 1'b0} + {1'b0, h_c, 1'b0} + 7'd4;
            arow_base <= 8'(9'(rd_c) * 9'(h_c) - 9'(ry_c) * 9'(h_c) - 9'd1);
            raw <= 8'(ra_c) * 8'(w_c);
            rxw <= 8'(rx_c) * 8'(w_c);
            clr_cnt <= '0;
          end
        end
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + TADDR_W'(1);
          if (clr_cnt == TADDR_W'(TALLY_DEPTH - 1)) begin
            pass <= PASS_UP;
            line <= 5'd1;
            pos <= 5'd0;
            weight <= h;
            first <= 1'b1;
          end
        end
        ST_EVAL: begin
          t_prev <= t_new;
          if (first) begin
            on_st <= init_on;
            first <= 1'b0;
            pos <= pos_adv;
          end else begin
            on_st <= on_new;
          end
        end
        ST_UPD: begin
          if (weight != 5'd1) begin
            weight <= weight - 5'd1;
            pos <= pos_adv;
          end else if (line != nline) begin
            line <= line + 5'd1;
            pos <= start_pos;
            weight <= extent;
            first <= 1'b1;
          end else if (pass != PASS_RIGHT) begin
            pass <= pass + 2'd1;
            line <= 5'd1;
            first <= 1'b1;
            // next pass flips orientation
            weight <= vert ? w : h;
            pos <= (pass == PASS_UP) ? w + 5'd1 : (pass == PASS_LEFT) ? h + 5'd1 : 5'd0;
          end else begin
            r <= 5'd0;
            c <= 5'd0;
            bits <= '0;
            arow <= arow_base;
          end
        end
        ST_ROW_ACC: begin
          if ({tally_q, 1'b0} >= {2'b0, factor}) bits[c] <= 1'b1;
          if (c == w - 5'd1) begin
            out_ch.valid <= 1'b1;
            out_ch.map_row <= r;
            out_ch.array_row <= arow;
            out_ch.array_index <= 15'(16'(arow) * 16'(raw) + 16'(rxw));
            out_ch.row_last <= (r == h - 5'd1);
          end else begin
            c <= c + 5'd1;
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            r <= r + 5'd1;
            c <= 5'd0;
            bits <= '0;
            arow <= arow - 8'd1;
            pass <= PASS_UP;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.row_bits = bits;
endmodule
